// File: hw/rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, widths and helper functions for the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int VALUE_W  = 64;
  localparam int BASE_W   = 5;
  localparam int DIGIT_W  = 4;
  localparam int SYM_W    = 8;
  localparam int NUM_SYMS = 16;
  localparam int MAX_BASE = 16;
  localparam int POW_DEPTH = 64;
  localparam int ADDR_W   = $clog2(POW_DEPTH);
  localparam int PROD_W   = VALUE_W + BASE_W;
  localparam int TRIAL_W  = VALUE_W + DIGIT_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [BASE_W-1:0]  RADIX_RST     = BASE_W'(10);
  localparam logic [VALUE_W-1:0] ALPHA_LO_RST  = 64'h3736353433323130;
  localparam logic [VALUE_W-1:0] ALPHA_HI_RST  = 64'h6665646362613938;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX    = 2'd0,
    REG_ALPHA_LO = 2'd1,
    REG_ALPHA_HI = 2'd2
  } cfg_idx_t;

  // Configuration as seen by the sequencer
  typedef struct packed {
    logic [BASE_W-1:0]  radix;
    logic [VALUE_W-1:0] alpha_lo;
    logic [VALUE_W-1:0] alpha_hi;
    logic               bad;
  } cfg_t;

  function automatic logic [SYM_W-1:0] sym_of(input logic [VALUE_W-1:0] lo,
                                              input logic [VALUE_W-1:0] hi,
                                              input logic [DIGIT_W-1:0] d);
    logic [2*VALUE_W-1:0] both;
    both = {hi, lo};
    return both[d*SYM_W +: SYM_W];
  endfunction

  // Radix out of range, or a repeated symbol among the ones in use
  function automatic logic alphabet_bad(input logic [BASE_W-1:0]  base,
                                        input logic [VALUE_W-1:0] lo,
                                        input logic [VALUE_W-1:0] hi);
    logic [2*VALUE_W-1:0] both;
    logic                 dup;
    both = {hi, lo};
    dup  = 1'b0;
    for (int i = 0; i < NUM_SYMS; i++) begin
      for (int j = i + 1; j < NUM_SYMS; j++) begin
        if ((BASE_W'(j) < base) && (both[i*SYM_W +: SYM_W] == both[j*SYM_W +: SYM_W])) begin
          dup = 1'b1;
        end
      end
    end
    return dup || (base < BASE_W'(2)) || (base > BASE_W'(MAX_BASE));
  endfunction

endpackage

// File: hw/rtl/rdc_cfg_regs.sv
// ----------------------------------------------------------------------------
// rdc_cfg_regs
// Radix and alphabet registers, with the alphabet validity check.
// ----------------------------------------------------------------------------
module rdc_cfg_regs import rdc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_data,
  output cfg_t                 cfg
);

  logic [BASE_W-1:0]  radix;
  logic [VALUE_W-1:0] alpha_lo;
  logic [VALUE_W-1:0] alpha_hi;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix    <= RADIX_RST;
      alpha_lo <= ALPHA_LO_RST;
      alpha_hi <= ALPHA_HI_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIX:    radix    <= cfg_data[BASE_W-1:0];
        REG_ALPHA_LO: alpha_lo <= cfg_data;
        REG_ALPHA_HI: alpha_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.radix    = radix;
    cfg.alpha_lo = alpha_lo;
    cfg.alpha_hi = alpha_hi;
    cfg.bad      = alphabet_bad(radix, alpha_lo, alpha_hi);
  end

endmodule

// File: hw/rtl/rdc_pow_ram.sv
// ----------------------------------------------------------------------------
// rdc_pow_ram
// Table of radix powers, one write and one registered read port.
// ----------------------------------------------------------------------------
module rdc_pow_ram import rdc_pkg::*; (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [VALUE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [VALUE_W-1:0] rd_data
);

  logic [VALUE_W-1:0] mem [POW_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/radix_digit_converter_core.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// Sequence: a multiply and a compare for each radix power tried, then for each
// digit a table read, 4 compare-subtract steps and an output load.
// Throughput: one item at a time; the input stalls until the sequencer is back
// in idle. A bad alphabet gives a single result, loaded from the error state.
// Output stalls hold the sequencer in place.
// Reset: synchronous; registers return to radix 10 and "0123456789abcdef".
// ----------------------------------------------------------------------------
module radix_digit_converter_core import rdc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // config
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_data,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [VALUE_W-1:0]   value,
  input  logic                 add_minus,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SYM_W-1:0]     symbol,
  output logic                 minus_first,
  output logic                 last,
  output logic                 bad_alphabet
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_CMP  = 7'b0000100,
    ST_RD   = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_EMIT = 7'b0100000,
    ST_ERR  = 7'b1000000
  } state_t;

  cfg_t               cfg;
  state_t             state;
  logic [VALUE_W-1:0] rem;
  logic [VALUE_W-1:0] pw;
  logic [PROD_W-1:0]  prod;
  logic [ADDR_W-1:0]  k;
  logic [1:0]         step;
  logic [DIGIT_W-1:0] digit;
  logic               minus;
  logic               first;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [VALUE_W-1:0] rd_data;

  logic [TRIAL_W-1:0] trial;
  logic               fits;
  logic               out_free;
  logic               in_xfer;
  logic               prod_ok;

  rdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rdc_pow_ram u_pow (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (k),
    .rd_data (rd_data)
  );

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // shared compare-subtract: trial multiple is power << step
  assign trial = {{DIGIT_W{1'b0}}, rd_data} << step;
  assign fits  = ({{DIGIT_W{1'b0}}, rem} >= trial);
  assign prod_ok = (prod[PROD_W-1:VALUE_W] == '0) && (prod[VALUE_W-1:0] <= rem);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k + ADDR_W'(1);
    wr_data = prod[VALUE_W-1:0];
    if (state == ST_IDLE) begin
      wr_en   = in_xfer;
      wr_addr = '0;
      wr_data = VALUE_W'(1);
    end else if (state == ST_CMP) begin
      wr_en = prod_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            rem   <= value;
            minus <= add_minus;
            first <= 1'b1;
            pw    <= VALUE_W'(1);
            k     <= '0;
            state <= cfg.bad ? ST_ERR : ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= {{BASE_W{1'b0}}, pw} * {{VALUE_W{1'b0}}, cfg.radix};
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (prod_ok) begin
            pw    <= prod[VALUE_W-1:0];
            k     <= k + ADDR_W'(1);
            state <= ST_MUL;
          end else begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          digit <= '0;
          step  <= 2'd3;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (fits) begin
            rem         <= rem - trial[VALUE_W-1:0];
            digit[step] <= 1'b1;
          end
          step <= step - 2'd1;
          if (step == 2'd0) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            first <= 1'b0;
            if (k == '0) begin
              state <= ST_IDLE;
            end else begin
              k     <= k - ADDR_W'(1);
              state <= ST_RD;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register; a new result loads once the previous one has transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= (state == ST_EMIT) || (state == ST_ERR);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == ST_ERR) begin
        symbol       <= '0;
        minus_first  <= 1'b0;
        last         <= 1'b1;
        bad_alphabet <= 1'b1;
      end else begin
        symbol       <= sym_of(cfg.alpha_lo, cfg.alpha_hi, digit);
        minus_first  <= minus && first;
        last         <= (k == '0);
        bad_alphabet <= 1'b0;
      end
    end
  end

endmodule

// File: tb/sv/rdc_digit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rdc_digit_checker
// Watches the register, value and digit channels of the radix digit converter.
// It keeps its own copy of the radix and alphabet and predicts the digit string
// of each accepted value. Each digit transfer is compared with the oldest
// pending prediction.
// ----------------------------------------------------------------------------
module rdc_digit_checker import rdc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [VALUE_W-1:0]   value,
  input  logic                 add_minus,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [SYM_W-1:0]     symbol,
  input  logic                 minus_first,
  input  logic                 last,
  input  logic                 bad_alphabet,
  output int                   pending_count,
  output int                   mismatch_count,
  output int                   values_seen,
  output int                   digits_seen,
  output int                   alphabet_errors
);

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             minus_first;
    logic             last;
    logic             bad_alphabet;
  } digit_t;

  digit_t             digits_due[$];
  logic [BASE_W-1:0]  radix_q;
  logic [VALUE_W-1:0] alpha_lo_q;
  logic [VALUE_W-1:0] alpha_hi_q;
  int                 mismatches;
  int                 n_values;
  int                 n_digits;
  int                 n_errors;

  initial begin
    mismatches      = 0;
    n_values        = 0;
    n_digits        = 0;
    n_errors        = 0;
  end

  function automatic logic [SYM_W-1:0] symbol_of(input int idx);
    if (idx < 8) begin
      return alpha_lo_q[idx*SYM_W +: SYM_W];
    end
    return alpha_hi_q[(idx-8)*SYM_W +: SYM_W];
  endfunction

  // radix in range and no repeat among the symbols in use
  function automatic bit alphabet_usable();
    int i;
    int j;
    if (radix_q < 2 || radix_q > MAX_BASE || radix_q > NUM_SYMS) begin
      return 1'b0;
    end
    for (i = 0; i < radix_q; i++) begin
      for (j = i + 1; j < radix_q; j++) begin
        if (symbol_of(i) == symbol_of(j)) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  task automatic predict_digits(input logic [VALUE_W-1:0] v, input logic m);
    logic [DIGIT_W-1:0] msd_first[$];
    logic [VALUE_W-1:0] rest;
    digit_t             d;
    if (!alphabet_usable()) begin
      d = '{symbol: '0, minus_first: 1'b0, last: 1'b1, bad_alphabet: 1'b1};
      digits_due.push_back(d);
      return;
    end
    rest = v;
    do begin
      msd_first.push_front(DIGIT_W'(rest % VALUE_W'(radix_q)));
      rest = rest / VALUE_W'(radix_q);
    end while (rest != 0);
    foreach (msd_first[k]) begin
      d.symbol       = symbol_of(msd_first[k]);
      d.minus_first  = (k == 0) ? m : 1'b0;
      d.last         = (k == msd_first.size() - 1);
      d.bad_alphabet = 1'b0;
      digits_due.push_back(d);
    end
  endtask

  task automatic check_field(input string name, input logic [SYM_W-1:0] want,
                             input logic [SYM_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    digit_t want;
    if (rst) begin
      radix_q    = RADIX_RST;
      alpha_lo_q = ALPHA_LO_RST;
      alpha_hi_q = ALPHA_HI_RST;
      digits_due.delete();
    end else begin
      // digits leaving first: a digit never belongs to a value taken at the same edge
      if (out_valid && !out_stall) begin
        n_digits++;
        if (bad_alphabet) begin
          n_errors++;
        end
        if (digits_due.size() == 0) begin
          $error("digit transfer with no value pending: symbol 0x%0h", symbol);
          mismatches++;
        end else begin
          want = digits_due.pop_front();
          check_field("symbol", want.symbol, symbol);
          check_field("minus_first", SYM_W'(want.minus_first), SYM_W'(minus_first));
          check_field("last", SYM_W'(want.last), SYM_W'(last));
          check_field("bad_alphabet", SYM_W'(want.bad_alphabet), SYM_W'(bad_alphabet));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RADIX: begin
            radix_q = cfg_data[BASE_W-1:0];
          end
          REG_ALPHA_LO: begin
            alpha_lo_q = cfg_data;
          end
          REG_ALPHA_HI: begin
            alpha_hi_q = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        n_values++;
        predict_digits(value, add_minus);
      end
    end
    pending_count   <= digits_due.size();
    mismatch_count  <= mismatches;
    values_seen     <= n_values;
    digits_seen     <= n_digits;
    alphabet_errors <= n_errors;
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the radix digit converter with directed corner values and random
// values under a range of radix and alphabet settings, good and bad, with
// random gaps on the value side and random stalls on the digit side.
// ----------------------------------------------------------------------------
module testbench import rdc_pkg::*;;

  localparam int                   LIMIT_CYCLES  = 4_000_000;
  localparam int                   SETTLE_CYCLES = 8;
  localparam int                   TAIL_CYCLES   = 600;
  localparam int                   BLOCKS        = 5;
  localparam int                   BLOCK_ITEMS   = 29;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic [VALUE_W-1:0]   ALL_ONES      = '1;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [VALUE_W-1:0]   cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [VALUE_W-1:0]   value       = '0;
  logic                 add_minus   = 1'b0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [SYM_W-1:0]     symbol;
  logic                 minus_first;
  logic                 last;
  logic                 bad_alphabet;

  int pending_count;
  int mismatch_count;
  int values_seen;
  int digits_seen;
  int alphabet_errors;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int settings_used = 0;
  int cycle_count   = 0;

  always #2 clk = ~clk;

  radix_digit_converter_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .add_minus    (add_minus),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .symbol       (symbol),
    .minus_first  (minus_first),
    .last         (last),
    .bad_alphabet (bad_alphabet)
  );

  rdc_digit_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .value           (value),
    .add_minus       (add_minus),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .symbol          (symbol),
    .minus_first     (minus_first),
    .last            (last),
    .bad_alphabet    (bad_alphabet),
    .pending_count   (pending_count),
    .mismatch_count  (mismatch_count),
    .values_seen     (values_seen),
    .digits_seen     (digits_seen),
    .alphabet_errors (alphabet_errors)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d digits still pending", cycle_count,
               pending_count);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // valid stays high between back-to-back transfers; it drops only on a gap or in a drain
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic m);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    value     <= v;
    add_minus <= m;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic drain(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) begin
      @(posedge clk);
    end
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
  endtask

  // radix word carries random upper bits: only the low 5 bits count
  task automatic reprogram(input logic [VALUE_W-1:0] radix_word,
                           input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi);
    drain(SETTLE_CYCLES);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_IDX_SPARE, {$urandom, $urandom});
    end
    write_reg(REG_RADIX, radix_word);
    write_reg(REG_ALPHA_LO, lo);
    write_reg(REG_ALPHA_HI, hi);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int               phase;
    int               i;
    int               j;
    bit               dup;
    logic [SYM_W-1:0] syms[NUM_SYMS];
    logic [SYM_W-1:0] b;
    logic [BASE_W-1:0] radix;
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    logic [VALUE_W-1:0] word;
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 21;
          stall_pct     = 85;
        end
        1: begin
          send_idle_pct = 85;
          stall_pct     = 21;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase

      if (phase == 0) begin
        // decimal after reset: zero, short, longest decimal string
        send_value(64'd0, 1'b0);
        send_value(64'd0, 1'b1);
        send_value(64'd9, 1'b0);
        send_value(64'd10, 1'b1);
        send_value(ALL_ONES, 1'b0);
        send_value(64'd1000000000000000000, 1'b1);
        // hex
        reprogram(64'd16, ALPHA_LO_RST, ALPHA_HI_RST);
        send_value(ALL_ONES, 1'b0);
        send_value(64'h8000_0000_0000_0000, 1'b1);
        send_value(64'h0123_4567_89ab_cdef, 1'b0);
        // binary: the full 64 digit string
        reprogram({59'h7ff_ffff_ffff_ffff, 5'd2}, ALPHA_LO_RST, ALPHA_HI_RST);
        send_value(ALL_ONES, 1'b0);
        send_value(64'h8000_0000_0000_0000, 1'b1);
        send_value(64'd1, 1'b1);
        // radix 3 with a zero byte as a symbol; zero repeats only past the radix
        reprogram(64'd3, 64'h0000_0000_0080_ff00, 64'd0);
        send_value(ALL_ONES, 1'b1);
        send_value(64'd0, 1'b0);
        send_value(64'd5, 1'b0);
        // radix out of range: 0, 1, 17, 31
        reprogram(64'hffff_ffff_ffff_ffe0, ALPHA_LO_RST, ALPHA_HI_RST);
        send_value(64'd123, 1'b1);
        reprogram(64'hffff_ffff_ffff_ffe1, ALPHA_LO_RST, ALPHA_HI_RST);
        send_value(64'd123, 1'b0);
        reprogram(64'd17, ALPHA_LO_RST, ALPHA_HI_RST);
        send_value(ALL_ONES, 1'b1);
        reprogram(ALL_ONES, ALPHA_LO_RST, ALPHA_HI_RST);
        send_value(64'd7, 1'b0);
        // last symbol repeats the first: bad at radix 16, fine at radix 15
        reprogram(64'd16, ALPHA_LO_RST, {8'h30, ALPHA_HI_RST[55:0]});
        send_value(ALL_ONES, 1'b1);
        reprogram(64'd15, ALPHA_LO_RST, {8'h30, ALPHA_HI_RST[55:0]});
        send_value(ALL_ONES, 1'b1);
        send_value(64'd0, 1'b0);
      end

      repeat (BLOCKS) begin
        for (i = 0; i < NUM_SYMS; i++) begin
          do begin
            b   = SYM_W'($urandom);
            dup = 1'b0;
            for (j = 0; j < i; j++) begin
              if (syms[j] == b) begin
                dup = 1'b1;
              end
            end
          end while (dup);
          syms[i] = b;
        end
        case ($urandom_range(0, 9))
          0:       radix = 5'd2;
          1:       radix = 5'd16;
          default: radix = BASE_W'($urandom_range(2, 16));
        endcase
        if ($urandom_range(0, 6) == 0) begin
          if ($urandom_range(0, 1) == 1) begin
            radix = ($urandom_range(0, 1) == 1) ? BASE_W'($urandom_range(0, 1))
                                                 : BASE_W'($urandom_range(17, 31));
          end else begin
            i = $urandom_range(1, radix - 1);
            j = $urandom_range(0, i - 1);
            syms[i] = syms[j];
          end
        end else if (radix < 16 && $urandom_range(0, 2) == 0) begin
          syms[15] = syms[$urandom_range(0, radix - 1)];
        end
        for (i = 0; i < 8; i++) begin
          lo[i*SYM_W +: SYM_W] = syms[i];
          hi[i*SYM_W +: SYM_W] = syms[i+8];
        end
        word          = {$urandom, $urandom};
        word[BASE_W-1:0] = radix;
        reprogram(word, lo, hi);

        repeat (BLOCK_ITEMS) begin
          case ($urandom_range(0, 9))
            0: v = '0;
            1: v = ALL_ONES;
            2: v = VALUE_W'($urandom_range(0, 300));
            3: begin
              // near a power of the radix, where the digit count steps
              p = 64'd1;
              if (radix >= 2) begin
                repeat ($urandom_range(0, 63)) begin
                  if (p <= ALL_ONES / VALUE_W'(radix)) begin
                    p = p * VALUE_W'(radix);
                  end
                end
              end
              v = p - VALUE_W'($urandom_range(0, 1));
            end
            default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
          endcase
          send_value(v, 1'($urandom));
        end
      end
    end

    drain(TAIL_CYCLES);
    $display("converted %0d values into %0d digit transfers over %0d register settings",
             values_seen, digits_seen, settings_used);
    $display("%0d of those transfers flagged a bad alphabet", alphabet_errors);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: radix_digit_converter_core.f
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_cfg_regs.sv
hw/rtl/rdc_pow_ram.sv
hw/rtl/radix_digit_converter_core.sv
tb/sv/rdc_digit_checker.sv
tb/sv/testbench.sv
